### rtl/core/bthc_pkg.sv
package bthc_pkg;

  // Timestamp width limits; helpers work on the widest form.
  localparam int TIME_BITS_DEF = 63;
  localparam int TIME_W_MAX    = 64;
  localparam int LIMIT_W       = 24;
  localparam int CFG_IDX_W     = 2;

  localparam logic [LIMIT_W-1:0] DEBOUNCE_RST = LIMIT_W'(200 * 1000);
  localparam logic [LIMIT_W-1:0] HOLD_RST     = LIMIT_W'(600 * 1000);
  localparam logic               TWO_BTN_RST  = 1'b1;
  localparam logic               ACTIVE_RST   = 1'b0;

  typedef enum logic [1:0] {
    INTENT_NONE = 2'd0,
    INTENT_PREV = 2'd1,
    INTENT_NEXT = 2'd2
  } intent_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TWO_BUTTONS  = 2'd0,
    REG_DEBOUNCE     = 2'd1,
    REG_HOLD         = 2'd2,
    REG_ACTIVE_LEVEL = 2'd3
  } cfg_reg_t;

  // Per-button status from a lane.
  typedef struct packed {
    logic down;
    logic was_down;
    logic rise;
    logic deb_ok;
  } lane_stat_t;

  // Update strobes to a lane.
  typedef struct packed {
    logic upd_down;
    logic set_press;
  } lane_ctl_t;

  // Strict elapsed test; a backwards step counts as zero elapsed.
  function automatic logic elapsed_over(input logic [TIME_W_MAX-1:0] now_v,
                                        input logic [TIME_W_MAX-1:0] then_v,
                                        input logic [LIMIT_W-1:0]    limit);
    logic [TIME_W_MAX:0] diff;
    diff = {1'b0, now_v} - {1'b0, then_v};
    return !diff[TIME_W_MAX] &&
           (diff[TIME_W_MAX-1:0] > {{(TIME_W_MAX-LIMIT_W){1'b0}}, limit});
  endfunction

endpackage

### rtl/core/bthc_if.sv
interface bthc_in_if #(
  parameter int TIME_BITS = bthc_pkg::TIME_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [TIME_BITS-1:0] now_us;
  logic                 level_a;
  logic                 level_b;

  modport source (output valid, cmd, now_us, level_a, level_b, input ready);
  modport sink   (input valid, cmd, now_us, level_a, level_b, output ready);
endinterface

interface bthc_out_if ();
  logic       valid;
  logic       ready;
  logic [1:0] intent;

  modport source (output valid, intent, input ready);
  modport sink   (input valid, intent, output ready);
endinterface

### rtl/core/bthc_lane.sv
module bthc_lane #(
  parameter int TIME_BITS = bthc_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [TIME_BITS-1:0]          now,
  input  logic                          level,
  input  logic                          active_level,
  input  logic [bthc_pkg::LIMIT_W-1:0]  debounce_time,
  input  bthc_pkg::lane_ctl_t           ctl,
  output bthc_pkg::lane_stat_t          stat
);
  import bthc_pkg::*;

  logic                 was_down_r;
  logic [TIME_BITS-1:0] last_press_r;
  logic                 down;

  assign down = (level == active_level);

  always_comb begin
    stat.down     = down;
    stat.was_down = was_down_r;
    stat.rise     = down & ~was_down_r;
    stat.deb_ok   = elapsed_over(TIME_W_MAX'(now), TIME_W_MAX'(last_press_r), debounce_time);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_down_r   <= 1'b0;
      last_press_r <= '0;
    end else begin
      if (ctl.upd_down) begin
        was_down_r <= down;
      end
      if (ctl.set_press) begin
        last_press_r <= now;
      end
    end
  end

endmodule

### rtl/core/bthc_merge.sv
module bthc_merge #(
  parameter int TIME_BITS = bthc_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          acc,
  input  logic                          cmd,
  input  logic                          two_buttons,
  input  logic [bthc_pkg::LIMIT_W-1:0]  hold_time,
  input  logic [TIME_BITS-1:0]          now,
  input  bthc_pkg::lane_stat_t          stat_a,
  input  bthc_pkg::lane_stat_t          stat_b,
  output bthc_pkg::lane_ctl_t           ctl_a,
  output bthc_pkg::lane_ctl_t           ctl_b,
  output bthc_pkg::intent_t             intent
);
  import bthc_pkg::*;

  logic [TIME_BITS-1:0] press_start_r;
  logic                 hold_rep_r;
  logic                 poll;
  logic                 fire_a;
  logic                 fire_b;
  logic                 hold_ok;
  logic                 hold_hit;
  logic                 start_press;

  assign poll    = acc & ~cmd;
  assign fire_a  = stat_a.rise & stat_a.deb_ok;
  assign fire_b  = stat_b.rise & stat_b.deb_ok;
  assign hold_ok = elapsed_over(TIME_W_MAX'(now), TIME_W_MAX'(press_start_r), hold_time);
  // held past the limit, not yet reported
  assign hold_hit    = stat_a.down & stat_a.was_down & ~hold_rep_r & hold_ok;
  assign start_press = poll & ~two_buttons & fire_a;

  always_comb begin
    ctl_a.upd_down  = acc;
    ctl_a.set_press = poll & fire_a;
    // B keeps its level on a poll where A fires
    ctl_b.upd_down  = acc & two_buttons & (cmd | ~fire_a);
    ctl_b.set_press = poll & two_buttons & ~fire_a & fire_b;
  end

  always_comb begin
    intent = INTENT_NONE;
    if (!cmd) begin
      if (two_buttons) begin
        if (fire_a) begin
          intent = INTENT_PREV;
        end else if (fire_b) begin
          intent = INTENT_NEXT;
        end
      end else if (hold_hit) begin
        intent = INTENT_PREV;
      end else if (!stat_a.down && stat_a.was_down && !hold_rep_r) begin
        intent = INTENT_NEXT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_start_r <= '0;
      hold_rep_r    <= 1'b0;
    end else begin
      if (start_press) begin
        press_start_r <= now;
        hold_rep_r    <= 1'b0;
      end else if (poll && !two_buttons && hold_hit) begin
        hold_rep_r <= 1'b1;
      end
    end
  end

endmodule

### rtl/core/button_tap_hold_classifier.sv
// Button tap/hold classifier. Each input item is a poll or a capture with a
// microsecond timestamp and the raw levels of pins A and B; every item gives
// exactly one result item carrying an intent (none, previous, next). Two
// lanes, one per button, hold that button's stored pressed flag and last
// press time and run its debounce test; a merge stage holds the hold timer
// state, picks the intent and steers which lane state updates. One item is
// accepted per clock: all state for the next item settles in the accepting cycle,
// and the result is in the output register the cycle after. The only stall is a
// result still waiting there, so throughput is one item per cycle while the sink
// keeps taking results. Registers are written through cfg_we/cfg_idx/cfg_wdata
// (0 two_buttons, 1 debounce_time, 2 hold_time, 3 active_level) by the user only
// while no item is in flight; the block itself does not enforce it. Timestamps
// must not wrap; a time earlier than the stored one counts as no time elapsed.
module button_tap_hold_classifier #(
  parameter int TIME_BITS = bthc_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bthc_in_if.sink                        in_ch,
  bthc_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [bthc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [bthc_pkg::LIMIT_W-1:0]   cfg_wdata
);
  import bthc_pkg::*;

  // configuration
  logic               two_buttons_r;
  logic [LIMIT_W-1:0] debounce_r;
  logic [LIMIT_W-1:0] hold_r;
  logic               active_level_r;

  // output register
  logic    out_valid_r;
  logic    out_valid_nxt;
  intent_t out_intent_r;

  logic       acc;
  lane_stat_t stat_a;
  lane_stat_t stat_b;
  lane_ctl_t  ctl_a;
  lane_ctl_t  ctl_b;
  intent_t    intent;

  // take a new item whenever the output slot is free or being drained
  assign in_ch.ready   = ~out_valid_r | out_ch.ready;
  assign acc           = in_ch.valid & in_ch.ready;
  assign out_valid_nxt = acc | (out_valid_r & ~out_ch.ready);

  assign out_ch.valid  = out_valid_r;
  assign out_ch.intent = out_intent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      two_buttons_r  <= TWO_BTN_RST;
      debounce_r     <= DEBOUNCE_RST;
      hold_r         <= HOLD_RST;
      active_level_r <= ACTIVE_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_TWO_BUTTONS:  two_buttons_r  <= cfg_wdata[0];
        REG_DEBOUNCE:     debounce_r     <= cfg_wdata;
        REG_HOLD:         hold_r         <= cfg_wdata;
        REG_ACTIVE_LEVEL: active_level_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_intent_r <= intent;
    end
  end

  // lane A: button A (the only button in one-button mode)
  bthc_lane #(.TIME_BITS(TIME_BITS)) u_lane_a (
    .clk           (clk),
    .rst_n         (rst_n),
    .now           (in_ch.now_us),
    .level         (in_ch.level_a),
    .active_level  (active_level_r),
    .debounce_time (debounce_r),
    .ctl           (ctl_a),
    .stat          (stat_a)
  );

  // lane B: button B, two-button mode only
  bthc_lane #(.TIME_BITS(TIME_BITS)) u_lane_b (
    .clk           (clk),
    .rst_n         (rst_n),
    .now           (in_ch.now_us),
    .level         (in_ch.level_b),
    .active_level  (active_level_r),
    .debounce_time (debounce_r),
    .ctl           (ctl_b),
    .stat          (stat_b)
  );

  // priority of A over B, hold timing, release detection
  bthc_merge #(.TIME_BITS(TIME_BITS)) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .cmd         (in_ch.cmd),
    .two_buttons (two_buttons_r),
    .hold_time   (hold_r),
    .now         (in_ch.now_us),
    .stat_a      (stat_a),
    .stat_b      (stat_b),
    .ctl_a       (ctl_a),
    .ctl_b       (ctl_b),
    .intent      (intent)
  );

endmodule

### rtl/core/bthc_checker.sv
module bthc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] intent
);
  import bthc_pkg::*;

  // every accepted item yields a result on the next cycle
  a_item_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted item produced no result");

  // a waiting result blocks new items
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("item taken while result stalled");

  // intent code is always a defined one
  a_intent_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (intent == INTENT_NONE || intent == INTENT_PREV ||
                   intent == INTENT_NEXT))
    else $error("undefined intent code");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(intent)))
    else $error("stalled result changed");

  // reset empties the output slot
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind button_tap_hold_classifier bthc_checker u_bthc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .intent    (out_ch.intent)
);
